/* hw/rtl/acs_pkg.sv */
package acs_pkg;

    localparam int SETTLE_READS = 4;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_IRQ   = 2'd1;
    localparam logic [1:0] FUNC_START = 2'd2;

    localparam logic [2:0] CK_IDENTIFY = 3'd0;
    localparam logic [2:0] CK_READ28   = 3'd1;
    localparam logic [2:0] CK_WRITE28  = 3'd2;
    localparam logic [2:0] CK_WRITE48  = 3'd4;

    localparam logic [2:0] OP_NONE = 3'd0;
    localparam logic [2:0] OP_INIT = 3'd1;
    localparam logic [2:0] OP_R28  = 3'd2;
    localparam logic [2:0] OP_W28  = 3'd3;
    localparam logic [2:0] OP_R48  = 3'd4;
    localparam logic [2:0] OP_W48  = 3'd5;

    localparam logic [1:0] KIND_REG    = 2'd0;
    localparam logic [1:0] KIND_SREAD  = 2'd1;
    localparam logic [1:0] KIND_SWRITE = 2'd2;
    localparam logic [1:0] KIND_STATUS = 2'd3;

    localparam logic [2:0] PHASE_IDLE      = 3'd0;
    localparam logic [2:0] PHASE_BUSY      = 3'd1;
    localparam logic [2:0] PHASE_IO_DONE   = 3'd2;
    localparam logic [2:0] PHASE_IO_FAIL   = 3'd3;
    localparam logic [2:0] PHASE_INIT_DONE = 3'd4;
    localparam logic [2:0] PHASE_INIT_FAIL = 3'd5;

    localparam logic [2:0] SEQ_NONE      = 3'd0;
    localparam logic [2:0] SEQ_INIT_SEL  = 3'd1;
    localparam logic [2:0] SEQ_INIT_CMD  = 3'd2;
    localparam logic [2:0] SEQ_INIT_XFER = 3'd3;
    localparam logic [2:0] SEQ_IO_SEL    = 3'd4;
    localparam logic [2:0] SEQ_TF28      = 3'd5;
    localparam logic [2:0] SEQ_TF48      = 3'd6;
    localparam logic [2:0] SEQ_IO_XFER   = 3'd7;

    localparam logic [3:0] REG_SECT    = 4'd2;
    localparam logic [3:0] REG_LBA0    = 4'd3;
    localparam logic [3:0] REG_LBA1    = 4'd4;
    localparam logic [3:0] REG_LBA2    = 4'd5;
    localparam logic [3:0] REG_DEVICE  = 4'd6;
    localparam logic [3:0] REG_COMMAND = 4'd7;
    localparam logic [3:0] REG_DEVCTRL = 4'd8;

    localparam int ST_ERR_BIT = 0;
    localparam int ST_DRQ_BIT = 3;
    localparam int ST_DF_BIT  = 5;

    localparam logic [7:0] ST_FLOAT      = 8'hFF;
    localparam logic [7:0] DH_LBA_MASTER = 8'hE0;
    localparam logic [7:0] CTRL_IRQ_ON   = 8'h00;
    localparam logic [7:0] CMD_IDENTIFY  = 8'hEC;
    localparam logic [7:0] CMD_READ28    = 8'h20;
    localparam logic [7:0] CMD_WRITE28   = 8'h30;
    localparam logic [7:0] CMD_READ48    = 8'h24;
    localparam logic [7:0] CMD_WRITE48   = 8'h34;

    typedef struct packed {
        logic [2:0]  seq;
        logic [2:0]  op;
        logic [47:0] lba;
        logic        acc;
        logic [2:0]  phase;
    } job_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  reg_index;
        logic [7:0]  reg_value;
        logic [47:0] xfer_lba;
        logic        accepted;
        logic [2:0]  phase;
        logic        last;
    } beat_t;

    function automatic logic is_bad(input logic [7:0] st);
        return (st == ST_FLOAT) || st[ST_ERR_BIT] || st[ST_DF_BIT];
    endfunction

    function automatic logic is_28(input logic [2:0] op);
        return (op == OP_R28) || (op == OP_W28);
    endfunction

endpackage

/* hw/rtl/acs_front.sv */
module acs_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  logic [1:0]         func,
    input  logic [7:0]         device_status,
    input  logic [2:0]         command_kind,
    input  logic [47:0]        start_lba,
    input  logic [15:0]        sector_total,
    output acs_pkg::job_t      job
);
    import acs_pkg::*;

    localparam logic [3:0] S_IDLE        = 4'd0;
    localparam logic [3:0] S_INIT_SELECT = 4'd1;
    localparam logic [3:0] S_INIT_CMD    = 4'd2;
    localparam logic [3:0] S_INIT_WAIT   = 4'd3;
    localparam logic [3:0] S_INIT_XFER   = 4'd4;
    localparam logic [3:0] S_INIT_DONE   = 4'd5;
    localparam logic [3:0] S_INIT_FAIL   = 4'd6;
    localparam logic [3:0] S_IO_SELECT   = 4'd7;
    localparam logic [3:0] S_IO_TASKFILE = 4'd8;
    localparam logic [3:0] S_IO_WAIT     = 4'd9;
    localparam logic [3:0] S_IO_XFER     = 4'd10;
    localparam logic [3:0] S_IO_DONE     = 4'd11;
    localparam logic [3:0] S_IO_FAIL     = 4'd12;

    logic [3:0]  step_reg, step_next;
    logic [2:0]  op_reg, op_next;
    logic        irq_reg, irq_next;
    logic [7:0]  lat_reg, lat_next;
    logic [2:0]  delay_reg, delay_next;
    logic [47:0] lba_reg, lba_next;
    logic [15:0] rem_reg, rem_next;
    logic        block_reg, block_next;

    logic        run;
    logic        go;
    logic [7:0]  st;
    logic [2:0]  seq;
    logic        acc;

    function automatic logic [2:0] phase_of(input logic [3:0] s);
        case (s)
            S_IDLE:      return PHASE_IDLE;
            S_IO_DONE:   return PHASE_IO_DONE;
            S_IO_FAIL:   return PHASE_IO_FAIL;
            S_INIT_DONE: return PHASE_INIT_DONE;
            S_INIT_FAIL: return PHASE_INIT_FAIL;
            default:     return PHASE_BUSY;
        endcase
    endfunction

    always_comb
    begin
        step_next  = step_reg;
        op_next    = op_reg;
        irq_next   = irq_reg;
        lat_next   = lat_reg;
        delay_next = delay_reg;
        lba_next   = lba_reg;
        rem_next   = rem_reg;
        block_next = block_reg;
        seq        = SEQ_NONE;
        acc        = 1'b0;
        run        = 1'b0;
        go         = 1'b0;
        st         = lat_reg;
        case (func)
            FUNC_TICK:
            begin
                if (delay_reg != 3'd0)
                begin
                    delay_next = delay_reg - 3'd1;
                    run        = (delay_reg == 3'd1);
                end
                else
                begin
                    run = 1'b1;
                end
                if (run)
                begin
                    case (step_reg)
                        S_INIT_SELECT:
                        begin
                            seq        = SEQ_INIT_SEL;
                            delay_next = 3'(SETTLE_READS);
                            step_next  = S_INIT_CMD;
                        end
                        S_INIT_CMD:
                        begin
                            seq       = SEQ_INIT_CMD;
                            irq_next  = 1'b0;
                            lat_next  = 8'd0;
                            step_next = S_INIT_WAIT;
                        end
                        S_INIT_WAIT:
                        begin
                            if (irq_reg)
                            begin
                                irq_next = 1'b0;
                                if (is_bad(lat_reg) || (!lat_reg[ST_DRQ_BIT]
                                        && is_bad(device_status)))
                                begin
                                    step_next = S_INIT_FAIL;
                                    op_next   = OP_NONE;
                                end
                                else if (lat_reg[ST_DRQ_BIT] || device_status[ST_DRQ_BIT])
                                begin
                                    step_next = S_INIT_XFER;
                                end
                            end
                        end
                        S_INIT_XFER:
                        begin
                            seq       = SEQ_INIT_XFER;
                            step_next = S_INIT_DONE;
                            op_next   = OP_NONE;
                        end
                        S_IO_SELECT:
                        begin
                            seq        = SEQ_IO_SEL;
                            delay_next = 3'(SETTLE_READS);
                            step_next  = S_IO_TASKFILE;
                        end
                        S_IO_TASKFILE:
                        begin
                            if (rem_reg == 16'd0)
                            begin
                                step_next = S_IO_DONE;
                                op_next   = OP_NONE;
                            end
                            else
                            begin
                                block_next = 1'b1;
                                seq        = is_28(op_reg) ? SEQ_TF28 : SEQ_TF48;
                                irq_next   = 1'b0;
                                lat_next   = 8'd0;
                                step_next  = S_IO_WAIT;
                            end
                        end
                        S_IO_WAIT:
                        begin
                            if (irq_reg)
                            begin
                                irq_next = 1'b0;
                                st       = lat_reg;
                                go       = 1'b1;
                            end
                            else if (!block_reg)
                            begin
                                st = device_status;
                                go = 1'b1;
                            end
                            if (go)
                            begin
                                if (is_bad(st))
                                begin
                                    step_next = S_IO_FAIL;
                                    op_next   = OP_NONE;
                                end
                                else if (st[ST_DRQ_BIT])
                                begin
                                    step_next = S_IO_XFER;
                                end
                                else if (!block_reg)
                                begin
                                    if (rem_reg == 16'd0)
                                    begin
                                        step_next = S_IO_DONE;
                                        op_next   = OP_NONE;
                                    end
                                    else
                                    begin
                                        step_next = S_IO_SELECT;
                                    end
                                end
                                else if (is_bad(device_status))
                                begin
                                    step_next = S_IO_FAIL;
                                    op_next   = OP_NONE;
                                end
                                else if (device_status[ST_DRQ_BIT])
                                begin
                                    step_next = S_IO_XFER;
                                end
                            end
                        end
                        S_IO_XFER:
                        begin
                            step_next = S_IO_WAIT;
                            if (block_reg)
                            begin
                                seq        = SEQ_IO_XFER;
                                block_next = 1'b0;
                                rem_next   = rem_reg - 16'd1;
                                if (is_28(op_reg))
                                begin
                                    lba_next = {20'd0, lba_reg[27:0] + 28'd1};
                                end
                                else
                                begin
                                    lba_next = lba_reg + 48'd1;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            FUNC_IRQ:
            begin
                lat_next = device_status;
                irq_next = 1'b1;
            end
            FUNC_START:
            begin
                if ((phase_of(step_reg) != PHASE_BUSY) && (command_kind <= CK_WRITE48)
                    && ((command_kind == CK_IDENTIFY) || (sector_total != 16'd0)))
                begin
                    acc        = 1'b1;
                    delay_next = 3'd0;
                    irq_next   = 1'b0;
                    lat_next   = 8'd0;
                    if (command_kind == CK_IDENTIFY)
                    begin
                        op_next   = OP_INIT;
                        step_next = S_INIT_SELECT;
                    end
                    else
                    begin
                        op_next    = command_kind + OP_INIT;
                        step_next  = S_IO_SELECT;
                        rem_next   = sector_total;
                        block_next = 1'b0;
                        if ((command_kind == CK_READ28) || (command_kind == CK_WRITE28))
                        begin
                            lba_next = {20'd0, start_lba[27:0]};
                        end
                        else
                        begin
                            lba_next = start_lba;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        job.seq   = seq;
        job.op    = op_reg;
        job.lba   = lba_reg;
        job.acc   = acc;
        job.phase = phase_of(step_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= S_IDLE;
            op_reg    <= OP_NONE;
            irq_reg   <= 1'b0;
            lat_reg   <= 8'd0;
            delay_reg <= 3'd0;
            lba_reg   <= 48'd0;
            rem_reg   <= 16'd0;
            block_reg <= 1'b0;
        end
        else if (take)
        begin
            step_reg  <= step_next;
            op_reg    <= op_next;
            irq_reg   <= irq_next;
            lat_reg   <= lat_next;
            delay_reg <= delay_next;
            lba_reg   <= lba_next;
            rem_reg   <= rem_next;
            block_reg <= block_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        delay_reg <= 3'(SETTLE_READS))
        else $error("settle count out of range");

endmodule

/* hw/rtl/acs_queue.sv */
module acs_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  acs_pkg::job_t  job_in,
    input  logic           pop,
    output acs_pkg::job_t  job_out,
    output logic           not_empty,
    output logic           full
);
    import acs_pkg::*;

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign not_empty = (count_reg != QCNT_W'(0));
    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign job_out   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? QPTR_W'(0)
                                                                   : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? QPTR_W'(0)
                                                                   : rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= job_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop && !full) |=> (count_reg == $past(count_reg) + QCNT_W'(1)))
        else $error("queue push lost");

endmodule

/* hw/rtl/acs_back.sv */
module acs_back (
    input  logic           clk,
    input  logic           rst_n,
    input  acs_pkg::job_t  job,
    input  logic           job_valid,
    output logic           job_pop,
    output acs_pkg::beat_t beat,
    output logic           beat_valid,
    input  logic           beat_ready
);
    import acs_pkg::*;

    logic [3:0] idx_reg, idx_next;
    logic [3:0] count;
    logic       load;
    logic       at_status;
    beat_t      cur;
    beat_t      beat_reg;
    logic       valid_reg;

    always_comb
    begin
        case (job.seq)
            SEQ_INIT_SEL:  count = 4'd2;
            SEQ_INIT_CMD:  count = 4'd5;
            SEQ_INIT_XFER: count = 4'd1;
            SEQ_IO_SEL:    count = 4'd1;
            SEQ_TF28:      count = 4'd5;
            SEQ_TF48:      count = 4'd9;
            SEQ_IO_XFER:   count = 4'd1;
            default:       count = 4'd0;
        endcase
    end

    assign at_status = (idx_reg == count);
    assign load      = !valid_reg || beat_ready;
    assign job_pop   = load && job_valid && at_status;
    assign idx_next  = at_status ? 4'd0 : idx_reg + 4'd1;

    always_comb
    begin
        cur           = '0;
        cur.kind      = KIND_REG;
        if (at_status)
        begin
            cur.kind     = KIND_STATUS;
            cur.accepted = job.acc;
            cur.phase    = job.phase;
            cur.last     = 1'b1;
        end
        else
        begin
            case (job.seq)
                SEQ_INIT_SEL:
                begin
                    cur.reg_index = (idx_reg == 4'd0) ? REG_DEVCTRL : REG_DEVICE;
                    cur.reg_value = (idx_reg == 4'd0) ? CTRL_IRQ_ON : DH_LBA_MASTER;
                end
                SEQ_INIT_CMD:
                begin
                    cur.reg_index = (idx_reg == 4'd4) ? REG_COMMAND : idx_reg + REG_SECT;
                    cur.reg_value = (idx_reg == 4'd4) ? CMD_IDENTIFY : 8'd0;
                end
                SEQ_INIT_XFER:
                begin
                    cur.kind = KIND_SREAD;
                end
                SEQ_IO_SEL:
                begin
                    cur.reg_index = REG_DEVICE;
                    cur.reg_value = is_28(job.op) ? (DH_LBA_MASTER | {4'd0, job.lba[27:24]})
                                                  : DH_LBA_MASTER;
                end
                SEQ_TF28:
                begin
                    cur.reg_index = (idx_reg == 4'd4) ? REG_COMMAND : idx_reg + REG_SECT;
                    case (idx_reg)
                        4'd0:    cur.reg_value = 8'd1;
                        4'd1:    cur.reg_value = job.lba[7:0];
                        4'd2:    cur.reg_value = job.lba[15:8];
                        4'd3:    cur.reg_value = job.lba[23:16];
                        default: cur.reg_value = (job.op == OP_R28) ? CMD_READ28 : CMD_WRITE28;
                    endcase
                end
                SEQ_TF48:
                begin
                    case (idx_reg)
                        4'd0:
                        begin
                            cur.reg_index = REG_SECT;
                            cur.reg_value = 8'd0;
                        end
                        4'd1:
                        begin
                            cur.reg_index = REG_LBA0;
                            cur.reg_value = job.lba[31:24];
                        end
                        4'd2:
                        begin
                            cur.reg_index = REG_LBA1;
                            cur.reg_value = job.lba[39:32];
                        end
                        4'd3:
                        begin
                            cur.reg_index = REG_LBA2;
                            cur.reg_value = job.lba[47:40];
                        end
                        4'd4:
                        begin
                            cur.reg_index = REG_SECT;
                            cur.reg_value = 8'd1;
                        end
                        4'd5:
                        begin
                            cur.reg_index = REG_LBA0;
                            cur.reg_value = job.lba[7:0];
                        end
                        4'd6:
                        begin
                            cur.reg_index = REG_LBA1;
                            cur.reg_value = job.lba[15:8];
                        end
                        4'd7:
                        begin
                            cur.reg_index = REG_LBA2;
                            cur.reg_value = job.lba[23:16];
                        end
                        default:
                        begin
                            cur.reg_index = REG_COMMAND;
                            cur.reg_value = (job.op == OP_R48) ? CMD_READ48 : CMD_WRITE48;
                        end
                    endcase
                end
                SEQ_IO_XFER:
                begin
                    cur.kind     = ((job.op == OP_R28) || (job.op == OP_R48)) ? KIND_SREAD
                                                                             : KIND_SWRITE;
                    cur.xfer_lba = job.lba;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && job_valid)
        begin
            beat_reg <= cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 4'd0;
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= job_valid;
            if (job_valid)
            begin
                idx_reg <= idx_next;
            end
        end
    end

    assign beat       = beat_reg;
    assign beat_valid = valid_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> ((beat_reg.kind == KIND_STATUS) == beat_reg.last))
        else $error("last not on status beat");

    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !beat_ready) |=> (valid_reg && $stable(beat_reg)))
        else $error("stalled beat changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= 4'd9)
        else $error("beat index out of range");

endmodule

/* hw/rtl/ata_pio_command_sequencer.sv */
// host-side ata pio sequencer for identify and lba28 / lba48 one-sector commands
// input stream s_*: one beat is a tick (alternate status), an interrupt (status
// byte) or a start request, selected by s_tuser
// output stream m_*: every input beat yields one to ten beats, register writes
// and sector transfer requests first, then one status beat marked by m_tlast
// the front keeps the sequencer state and handles one input beat per cycle while
// the queue has room, passing one job per input into a four-entry queue
// the back expands each job into beats, one per cycle unless m_tready stalls,
// through an output register; a taken input is written into a queue slot, then
// into the back's output register, before its first beat shows on m_*
// an input yields as many beats as its job holds, from one for an interrupt up to
// ten for a 48-bit taskfile tick; a job leaves the queue with its status beat
// a stalled m_tready holds the beat; input keeps flowing until the queue fills
// reset puts the sequencer idle with an empty queue and no beat pending
module ata_pio_command_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // device_status[7:0], command_kind[10:8], start_lba[58:11], sector_total[74:59]
    input  logic [79:0] s_tdata,
    // func[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // reg_index[3:0], reg_value[11:4], xfer_lba[59:12], accepted[60], phase[63:61]
    output logic [63:0] m_tdata,
    // kind[1:0]
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);
    import acs_pkg::*;

    job_t  front_job;
    job_t  head_job;
    beat_t beat;
    logic  take;
    logic  head_valid;
    logic  head_pop;
    logic  q_full;

    assign s_tready = !q_full;
    assign take     = s_tvalid && s_tready;

    acs_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .func          (s_tuser),
        .device_status (s_tdata[7:0]),
        .command_kind  (s_tdata[10:8]),
        .start_lba     (s_tdata[58:11]),
        .sector_total  (s_tdata[74:59]),
        .job           (front_job)
    );

    acs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take),
        .job_in    (front_job),
        .pop       (head_pop),
        .job_out   (head_job),
        .not_empty (head_valid),
        .full      (q_full)
    );

    acs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job        (head_job),
        .job_valid  (head_valid),
        .job_pop    (head_pop),
        .beat       (beat),
        .beat_valid (m_tvalid),
        .beat_ready (m_tready)
    );

    assign m_tuser = beat.kind;
    assign m_tlast = beat.last;
    assign m_tdata = {beat.phase, beat.accepted, beat.xfer_lba, beat.reg_value,
                      beat.reg_index};

endmodule
